>>> rtl/scc_pkg.sv
package scc_pkg;

  localparam int VERTEX_W = 6;
  localparam int COUNT_W = 7;
  localparam int EDGE_W = 2 * VERTEX_W;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF = 256;
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    MODE_DIRECTED = 2'd0,
    MODE_BOTH     = 2'd1,
    MODE_RUN      = 2'd2,
    MODE_CLEAR    = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD2,
    ST_F_START,
    ST_F_READ,
    ST_F_CHECK,
    ST_F_POP,
    ST_R_START,
    ST_R_FIN,
    ST_R_POP,
    ST_R_POPW,
    ST_R_READ,
    ST_R_CHECK,
    ST_O_READ,
    ST_O_LOAD,
    ST_O_SHOW
  } state_t;

endpackage

>>> rtl/scc_ram.sv
module scc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/strongly_connected_components_unit.sv
// Channel   Direction  Signals
// in        sink       in_valid, in_ready, mode, from_vertex, to_vertex
// out       source     out_valid, out_ready, vertex, component, last,
//                      component_total, edges_dropped
// cfg       sink       cfg_valid, cfg_ready, cfg_data (vertex_count)
//
// A MODE_BOTH edge is stored both ways; ST_LOAD2 writes the reverse edge;
// clear empties the edge store and clears edges_dropped. In a run, each
// vertex scan in both passes reads each stored edge through a READ and a CHECK
// state, bounded by the single read port of the edge store.
// rst is synchronous; it empties the edge store and sets vertex_count to 64.
// A stalled result holds the block; inputs and cfg writes are taken only when idle.
module strongly_connected_components_unit #(
  parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES = scc_pkg::MAX_EDGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [scc_pkg::VERTEX_W-1:0] from_vertex,
  input  logic [scc_pkg::VERTEX_W-1:0] to_vertex,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [scc_pkg::VERTEX_W-1:0] vertex,
  output logic [scc_pkg::VERTEX_W-1:0] component,
  output logic                        last,
  output logic [scc_pkg::COUNT_W-1:0]  component_total,
  output logic                        edges_dropped,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [scc_pkg::COUNT_W-1:0]  cfg_data
);

  import scc_pkg::*;

  localparam int KW = $clog2(MAX_EDGES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int SW = VERTEX_W + KW;

  state_t state, state_next;
  logic [COUNT_W-1:0] vc;
  logic [COUNT_W-1:0] nv;
  logic [KW-1:0] edge_total, edge_total_next;
  logic drop_seen, drop_seen_next;
  logic [EDGE_W-1:0] pend, pend_next;
  logic [MAX_VERTICES-1:0] visited, visited_next;
  logic [COUNT_W-1:0] s, s_next, done, done_next, sp, sp_next;
  logic [COUNT_W-1:0] i, i_next, count, count_next, ov, ov_next;
  logic [VERTEX_W-1:0] top_v, top_v_next;
  logic [KW-1:0] k, k_next;
  logic out_valid_next, last_next;
  logic [VERTEX_W-1:0] vertex_next, component_next;
  logic [COUNT_W-1:0] total_next;
  logic [KW:0] need_sum;
  logic [COUNT_W-1:0] ov_inc;

  logic e_we;
  logic [EAW-1:0] e_waddr, e_raddr;
  logic [EDGE_W-1:0] e_wdata, e_rdata;
  logic s_we;
  logic [VIW-1:0] s_waddr, s_raddr, f_waddr, f_raddr, l_waddr, l_raddr;
  logic [SW-1:0] s_wdata, s_rdata;
  logic f_we, l_we;
  logic [VERTEX_W-1:0] f_wdata, f_rdata, l_wdata, l_rdata;
  logic [VERTEX_W-1:0] e_src, e_dst;

  assign nv = (vc == '0) ? COUNT_W'(1) :
              (vc > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES) : vc;
  // a cfg write goes first when both are offered in the same cycle
  assign in_ready = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign e_src = e_rdata[EDGE_W-1:VERTEX_W];
  assign e_dst = e_rdata[VERTEX_W-1:0];
  assign ov_inc = ov + COUNT_W'(1);

  scc_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edges (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );
  scc_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );
  scc_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_VERTICES)) u_finish (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );
  scc_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_VERTICES)) u_label (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      vc <= VERTEX_COUNT_RESET;
      edge_total <= '0;
      drop_seen <= 1'b0;
      visited <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        vc <= cfg_data;
      end
      edge_total <= edge_total_next;
      drop_seen <= drop_seen_next;
      visited <= visited_next;
      out_valid <= out_valid_next;
    end
    pend <= pend_next;
    s <= s_next;
    done <= done_next;
    sp <= sp_next;
    i <= i_next;
    count <= count_next;
    ov <= ov_next;
    top_v <= top_v_next;
    k <= k_next;
    vertex <= vertex_next;
    component <= component_next;
    last <= last_next;
    component_total <= total_next;
  end

  assign edges_dropped = drop_seen;

  always_comb begin
    state_next = state;
    edge_total_next = edge_total;
    drop_seen_next = drop_seen;
    pend_next = pend;
    visited_next = visited;
    s_next = s;
    done_next = done;
    sp_next = sp;
    i_next = i;
    count_next = count;
    ov_next = ov;
    top_v_next = top_v;
    k_next = k;
    out_valid_next = out_valid;
    vertex_next = vertex;
    component_next = component;
    last_next = last;
    total_next = component_total;
    e_we = 1'b0;
    e_waddr = edge_total[EAW-1:0];
    e_wdata = {from_vertex, to_vertex};
    e_raddr = k[EAW-1:0];
    s_we = 1'b0;
    s_waddr = '0;
    s_wdata = '0;
    s_raddr = '0;
    f_we = 1'b0;
    f_waddr = done[VIW-1:0];
    f_wdata = top_v;
    f_raddr = '0;
    l_we = 1'b0;
    l_waddr = '0;
    l_wdata = count[VERTEX_W-1:0];
    l_raddr = ov[VIW-1:0];
    need_sum = {1'b0, edge_total} + ((mode == MODE_BOTH) ? (KW+1)'(2) : (KW+1)'(1));

    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (mode_t'(mode))
            MODE_DIRECTED, MODE_BOTH: begin
              if ({1'b0, from_vertex} >= nv || {1'b0, to_vertex} >= nv ||
                  need_sum > (KW+1)'(MAX_EDGES)) begin
                drop_seen_next = 1'b1;
              end else begin
                e_we = 1'b1;
                edge_total_next = edge_total + KW'(1);
                if (mode == MODE_BOTH) begin
                  pend_next = {to_vertex, from_vertex};
                  state_next = ST_LOAD2;
                end
              end
            end
            MODE_RUN: begin
              visited_next = '0;
              s_next = '0;
              done_next = '0;
              state_next = ST_F_START;
            end
            MODE_CLEAR: begin
              edge_total_next = '0;
              drop_seen_next = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD2: begin
        e_we = 1'b1;
        e_wdata = pend;
        edge_total_next = edge_total + KW'(1);
        state_next = ST_IDLE;
      end
      ST_F_START: begin
        if (s == nv) begin
          visited_next = '0;
          count_next = '0;
          i_next = done;
          state_next = ST_R_START;
        end else if (visited[s[VIW-1:0]]) begin
          s_next = s + COUNT_W'(1);
        end else begin
          visited_next[s[VIW-1:0]] = 1'b1;
          top_v_next = s[VERTEX_W-1:0];
          k_next = '0;
          sp_next = COUNT_W'(1);
          state_next = ST_F_READ;
        end
      end
      ST_F_READ: begin
        if (k == edge_total) begin
          // vertex finished: record it and pop
          f_we = 1'b1;
          done_next = done + COUNT_W'(1);
          if (sp == COUNT_W'(1)) begin
            sp_next = '0;
            s_next = s + COUNT_W'(1);
            state_next = ST_F_START;
          end else begin
            sp_next = sp - COUNT_W'(1);
            s_raddr = VIW'(sp - COUNT_W'(2));
            state_next = ST_F_POP;
          end
        end else begin
          state_next = ST_F_CHECK;
        end
      end
      ST_F_CHECK: begin
        k_next = k + KW'(1);
        if (e_src == top_v && {1'b0, e_dst} < nv && !visited[e_dst[VIW-1:0]]) begin
          // descend: park current vertex with its resume cursor
          s_we = 1'b1;
          s_waddr = VIW'(sp - COUNT_W'(1));
          s_wdata = {top_v, k + KW'(1)};
          sp_next = sp + COUNT_W'(1);
          visited_next[e_dst[VIW-1:0]] = 1'b1;
          top_v_next = e_dst;
          k_next = '0;
        end
        state_next = ST_F_READ;
      end
      ST_F_POP: begin
        top_v_next = s_rdata[SW-1:KW];
        k_next = s_rdata[KW-1:0];
        state_next = ST_F_READ;
      end
      ST_R_START: begin
        if (i == '0) begin
          ov_next = '0;
          state_next = ST_O_READ;
        end else begin
          f_raddr = VIW'(i - COUNT_W'(1));
          state_next = ST_R_FIN;
        end
      end
      ST_R_FIN: begin
        if (visited[f_rdata[VIW-1:0]]) begin
          i_next = i - COUNT_W'(1);
          state_next = ST_R_START;
        end else begin
          visited_next[f_rdata[VIW-1:0]] = 1'b1;
          l_we = 1'b1;
          l_waddr = f_rdata[VIW-1:0];
          s_we = 1'b1;
          s_waddr = '0;
          s_wdata = {f_rdata, KW'(0)};
          sp_next = COUNT_W'(1);
          state_next = ST_R_POP;
        end
      end
      ST_R_POP: begin
        if (sp == '0) begin
          count_next = count + COUNT_W'(1);
          i_next = i - COUNT_W'(1);
          state_next = ST_R_START;
        end else begin
          s_raddr = VIW'(sp - COUNT_W'(1));
          sp_next = sp - COUNT_W'(1);
          state_next = ST_R_POPW;
        end
      end
      ST_R_POPW: begin
        top_v_next = s_rdata[SW-1:KW];
        k_next = '0;
        state_next = ST_R_READ;
      end
      ST_R_READ: begin
        state_next = (k == edge_total) ? ST_R_POP : ST_R_CHECK;
      end
      ST_R_CHECK: begin
        k_next = k + KW'(1);
        if (e_dst == top_v && {1'b0, e_src} < nv && !visited[e_src[VIW-1:0]]) begin
          visited_next[e_src[VIW-1:0]] = 1'b1;
          l_we = 1'b1;
          l_waddr = e_src[VIW-1:0];
          s_we = 1'b1;
          s_waddr = sp[VIW-1:0];
          s_wdata = {e_src, KW'(0)};
          sp_next = sp + COUNT_W'(1);
        end
        state_next = ST_R_READ;
      end
      ST_O_READ: begin
        state_next = ST_O_LOAD;
      end
      ST_O_LOAD: begin
        vertex_next = ov[VERTEX_W-1:0];
        component_next = l_rdata;
        last_next = (ov_inc == nv);
        total_next = (ov_inc == nv) ? count : '0;
        out_valid_next = 1'b1;
        state_next = ST_O_SHOW;
      end
      ST_O_SHOW: begin
        if (out_ready) begin
          out_valid_next = 1'b0;
          ov_next = ov_inc;
          state_next = last ? ST_IDLE : ST_O_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/scc_checker.sv
module scc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [scc_pkg::VERTEX_W-1:0]  vertex,
  input logic                          last,
  input logic [scc_pkg::COUNT_W-1:0]   component_total
);

  import scc_pkg::*;

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(vertex))
    else $error("result changed while stalled");

  a_total_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> component_total == '0)
    else $error("component_total set before last result");

  a_total_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> component_total != '0)
    else $error("zero component count on last result");

  a_no_input_during_output: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while results pending");

endmodule

bind strongly_connected_components_unit scc_checker u_scc_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .vertex(vertex), .last(last),
  .component_total(component_total)
);
